// ===== hw/rtl/ins_sort_pkg.sv =====
package ins_sort_pkg;

    // Default number of entries in the sorted store.
    localparam int DEF_CAPACITY = 16;

    // Width of the position field in a result beat.
    localparam int POS_W = 4;

    // One input beat.
    typedef struct packed {
        logic signed [31:0] value;
        logic               new_set;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0]   sorted_value;
        logic [POS_W-1:0]     position;
        logic                 last;
        logic                 overflow;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic insert;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic last_beat;
    } dp_sts_t;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_INSERT = 3'b010,
        ST_EMIT   = 3'b100
    } ctrl_state_t;

endpackage

// ===== hw/rtl/ins_sort_ctrl.sv =====
module ins_sort_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ins_sort_pkg::dp_sts_t  sts,
    output ins_sort_pkg::dp_cmd_t  cmd
);
    import ins_sort_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.insert  = 1'b0;
        cmd.emit    = 1'b0;
        item_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
                if (item_valid)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.last_beat)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ins_sort_dp.sv =====
module ins_sort_dp #(
    parameter int CAPACITY = ins_sort_pkg::DEF_CAPACITY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ins_sort_pkg::item_t    item,
    input  ins_sort_pkg::dp_cmd_t  cmd,
    output ins_sort_pkg::dp_sts_t  sts,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ins_sort_pkg::result_t  result
);
    import ins_sort_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // Sorted entries; only those below the fill count hold data.
    logic signed [31:0] entry_reg [CAPACITY];
    logic signed [31:0] entry_next [CAPACITY];

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   emit_idx_reg;
    logic               dropped_reg;
    logic               res_valid_reg;
    result_t            res_reg;
    item_t              item_reg;

    logic [CNT_W-1:0]   base_count;
    logic               full;
    logic [CAPACITY-1:0] below;
    logic [CNT_W-1:0]   emit_pos;
    logic [IDX_W+POS_W-1:0] pos_ext;

    // Starting fill for this insertion: a new set empties the store.
    assign base_count = item_reg.new_set ? '0 : count_reg;
    assign full       = (base_count == CNT_W'(CAPACITY));
    assign count_next = full ? base_count : base_count + CNT_W'(1);

    // Each cell compares its own entry with the incoming value.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            below[i] = (CNT_W'(i) < base_count) && (entry_reg[i] < item_reg.value);
        end
    end

    // Next entries: insertion shifts up from the slot, emission rotates the
    // occupied entries down by one so that entry zero is always the next beat.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.insert && !full)
            begin
                if (below[i])
                begin
                    entry_next[i] = entry_reg[i];
                end
                else if (i == 0)
                begin
                    entry_next[i] = item_reg.value;
                end
                else if (below[(i > 0) ? i - 1 : 0])
                begin
                    entry_next[i] = item_reg.value;
                end
                else
                begin
                    entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.emit)
            begin
                if (CNT_W'(i) + CNT_W'(1) == count_reg)
                begin
                    entry_next[i] = entry_reg[0];
                end
                else if ((CNT_W'(i) + CNT_W'(1) < count_reg) && (i < CAPACITY - 1))
                begin
                    entry_next[i] = entry_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Beat bookkeeping.
    assign emit_pos      = CNT_W'(emit_idx_reg);
    assign pos_ext       = {{POS_W{1'b0}}, emit_idx_reg};
    assign sts.last_beat = (emit_pos + CNT_W'(1) == count_reg);
    assign sts.out_free  = !res_valid_reg || !result_stall;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                count_reg    <= count_next;
                dropped_reg  <= full;
                emit_idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                emit_idx_reg <= sts.last_beat ? '0 : emit_idx_reg + IDX_W'(1);
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
        if (cmd.emit)
        begin
            res_reg.sorted_value <= entry_reg[0];
            res_reg.position     <= pos_ext[POS_W-1:0];
            res_reg.last         <= sts.last_beat;
            res_reg.overflow     <= dropped_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hw/rtl/insertion_sorter_unit.sv =====
// Channel   Direction  Beat type  Handshake
// item      in         item_t     item_valid / item_stall
// result    out        result_t   result_valid / result_stall
//
// An accepted item is captured, then inserted into the store, and then one beat
// per stored entry is emitted. The emission rate is set by the single output
// register, one beat a cycle while the result channel is not stalled.
// Reset empties the store; entry contents are not cleared.
// A stall on the result channel holds the current beat and pauses emission.
// item_stall is high from acceptance until the last beat is loaded.
module insertion_sorter_unit #(
    parameter int CAPACITY = ins_sort_pkg::DEF_CAPACITY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ins_sort_pkg::item_t    item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ins_sort_pkg::result_t  result
);
    import ins_sort_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer.
    ins_sort_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Store, comparators and output register.
    ins_sort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hw/rtl/ins_sort_chk.sv =====
module ins_sort_chk (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  ins_sort_pkg::result_t  result
);
    import ins_sort_pkg::*;

    // A stalled beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // The block is busy right after taking an item.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item channel open right after acceptance");

    // No new item while a burst is still going out.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> item_stall)
        else $error("item channel open during result burst");

    // A one-beat burst never comes from a full store.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last && (result.position == '0) |-> !result.overflow)
        else $error("single-entry burst flagged overflow");

endmodule

bind insertion_sorter_unit ins_sort_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
